// ===== hw/rtl/true_peak_oversampling_meter_core_macros.svh =====
// Assertion macros for the true peak meter RTL.
// Included by modules that carry concurrent checks; no other dependencies.
`ifndef TRUE_PEAK_OVERSAMPLING_METER_CORE_MACROS_SVH
`define TRUE_PEAK_OVERSAMPLING_METER_CORE_MACROS_SVH
`ifndef ASSERT_OFF
`define TPOM_ASSERT_IMP(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("tpom: implication check failed");
`define TPOM_ASSERT_NXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("tpom: next-cycle check failed");
`else
`define TPOM_ASSERT_IMP(label, clk, rstn, ante, cons)
`define TPOM_ASSERT_NXT(label, clk, rstn, ante, cons)
`endif
`endif

// ===== hw/rtl/tpom_pkg.sv =====
// Shared constants, codes and coefficient ROM functions for the true peak meter.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package tpom_pkg;

    localparam int SAMPLE_BITS = 24;
    localparam int COEF_BITS   = 18;
    localparam int COEF_FRAC   = COEF_BITS - 1;
    localparam int PEAK_BITS   = SAMPLE_BITS + 1;
    localparam int I0_FRAC     = 24;
    localparam int G_SHIFT     = 4;
    localparam int I0_TERMS    = 40;

    localparam logic [PEAK_BITS-1:0] PEAK_MAX = '1;

    localparam logic [1:0] MODE_1X = 2'd0;
    localparam logic [1:0] MODE_2X = 2'd1;
    localparam logic [1:0] MODE_4X = 2'd2;

    localparam logic OP_SAMPLE = 1'b0;
    localparam logic OP_CLEAR  = 1'b1;

    typedef logic signed [COEF_BITS-1:0] coef_t;

    // Shift-subtract division, elaboration only.
    function automatic logic [63:0] udiv64(input logic [63:0] a, input logic [63:0] b);
        logic [64:0] rem;
        logic [63:0] quo;
        rem = '0;
        quo = '0;
        for (int i = 63; i >= 0; i--) begin
            rem = {rem[63:0], a[i]};
            if (rem >= {1'b0, b}) begin
                rem    = rem - {1'b0, b};
                quo[i] = 1'b1;
            end
        end
        return quo;
    endfunction

    // Truncated modified Bessel series, Q24 in and out.
    function automatic logic [63:0] bessel_i0(input logic [63:0] q);
        logic [63:0] term;
        logic [63:0] sum;
        logic [63:0] jj;
        term = 64'd1 << I0_FRAC;
        sum  = term;
        for (int j = 1; j < I0_TERMS; j++) begin
            jj   = 64'(j);
            term = udiv64(term * q, (jj * jj) << I0_FRAC);
            sum  = sum + term;
        end
        return sum;
    endfunction

    // Tap k of phase p for factor m, unity gain per phase, signed Q1.17.
    function automatic coef_t tap_coef(input int m, input int taps, input int p, input int k);
        longint      n;
        longint      d;
        longint      g;
        longint      g_sel;
        longint      sum;
        logic [63:0] n2;
        logic [63:0] ad;
        logic [63:0] q;
        logic [63:0] mag;
        logic [63:0] num;
        logic [63:0] den;
        logic [63:0] r;
        logic [63:0] lim;
        logic        neg;
        coef_t       res;
        n     = longint'(m) * longint'(taps);
        n2    = 64'(n * n);
        sum   = 0;
        g_sel = 0;
        res   = '0;
        for (int kk = 0; kk < taps; kk++) begin
            d   = 2 * longint'(p + kk * m) - n + 1;
            ad  = (d < 0) ? 64'(-d) : 64'(d);
            q   = udiv64((64'd16 * (n2 - ad * ad)) << I0_FRAC, n2);
            mag = udiv64(bessel_i0(q) << G_SHIFT, ad);
            neg = ((kk % 2) != 0) != (d < 0);
            g   = neg ? -longint'(mag) : longint'(mag);
            sum = sum + g;
            if (kk == k) begin
                g_sel = g;
            end
        end
        if (sum != 0) begin
            num = 64'((g_sel < 0) ? -g_sel : g_sel) << COEF_FRAC;
            den = 64'((sum < 0) ? -sum : sum);
            r   = udiv64(2 * num + den, 2 * den);
            neg = (g_sel < 0) != (sum < 0);
            lim = (64'd1 << COEF_FRAC) - (neg ? 64'd0 : 64'd1);
            if (r > lim) begin
                r = lim;
            end
            res = neg ? COEF_BITS'(-r) : COEF_BITS'(r);
        end
        return res;
    endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/true_peak_oversampling_meter_core.sv =====
// Clear and ignored items go straight to the result handshake and 1x items pass through the write
// state only; 2x and 4x items run every tap through one shared MAC, one tap/cycle, then drain.
// Items are taken one at a time; the next item is taken while the previous result waits.
// Synchronous active-low reset clears control state, slot, peak and history
// valid bits (history reads as zero); oversampling mode resets to 4x.
// Depends on tpom_pkg and the macros header.
`timescale 1ns / 1ps
`default_nettype none
`include "true_peak_oversampling_meter_core_macros.svh"
module true_peak_oversampling_meter_core
    import tpom_pkg::*;
#(
    parameter int TAPS_PER_PHASE = 16,
    parameter int MAX_CHANNELS   = 8
) (
    input  wire                           aclk,
    input  wire                           aresetn,
    input  wire                           cfg_wr_en,
    input  wire  [1:0]                    cfg_wr_data,
    input  wire                           s_valid,
    output logic                          s_ready,
    input  wire                           s_operation,
    input  wire  [3:0]                    s_channel,
    input  wire  signed [SAMPLE_BITS-1:0] s_sample,
    input  wire                           s_frame_last,
    output logic                          m_valid,
    input  wire                           m_ready,
    output logic [PEAK_BITS-1:0]          m_peak_level
);

    localparam int SLOT_W = $clog2(TAPS_PER_PHASE);
    localparam int CH_IW  = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
    localparam int PROD_W = SAMPLE_BITS + COEF_BITS;
    localparam int ACC_W  = PROD_W + SLOT_W;
    localparam int MAG_W  = ACC_W + 1 - COEF_FRAC;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_WRITE = 3'd1;
    localparam logic [2:0] ST_MAC   = 3'd2;
    localparam logic [2:0] ST_DRAIN = 3'd3;
    localparam logic [2:0] ST_OUT   = 3'd4;

    localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(TAPS_PER_PHASE - 1);

    // coefficient ROMs, index k*m + p
    coef_t coef2_rom [2*TAPS_PER_PHASE];
    coef_t coef4_rom [4*TAPS_PER_PHASE];

    genvar gk, gp;
    generate
        for (gk = 0; gk < TAPS_PER_PHASE; gk++) begin : g_tap
            for (gp = 0; gp < 2; gp++) begin : g_ph2
                localparam coef_t C = tap_coef(2, TAPS_PER_PHASE, gp, gk);
                assign coef2_rom[gk*2+gp] = C;
            end
            for (gp = 0; gp < 4; gp++) begin : g_ph4
                localparam coef_t C = tap_coef(4, TAPS_PER_PHASE, gp, gk);
                assign coef4_rom[gk*4+gp] = C;
            end
        end
    endgenerate

    logic [2:0]                     state_reg, state_next;
    logic [1:0]                     mode_reg;
    logic                           op_reg;
    logic [3:0]                     ch_reg;
    logic signed [SAMPLE_BITS-1:0]  sample_reg;
    logic                           last_reg;
    logic [SLOT_W-1:0]              slot_reg;
    logic [SLOT_W-1:0]              at_reg;
    logic [SLOT_W-1:0]              k_reg;
    logic [1:0]                     p_reg;
    logic [PEAK_BITS-1:0]           peak_reg;
    logic [MAX_CHANNELS-1:0][TAPS_PER_PHASE-1:0] hist_ok_reg;

    logic signed [SAMPLE_BITS-1:0]  hist_mem [MAX_CHANNELS][TAPS_PER_PHASE];
    logic signed [SAMPLE_BITS-1:0]  rd_data_reg;
    logic                           rd_ok_reg;
    coef_t                          coef_reg;
    logic                           s1_vld_reg, s1_last_reg;
    logic signed [PROD_W-1:0]       prod_reg;
    logic                           s2_vld_reg, s2_last_reg;
    logic signed [ACC_W-1:0]        acc_reg;
    logic signed [ACC_W-1:0]        fin_reg;
    logic                           fin_vld_reg;
    logic [MAG_W-1:0]               mag_reg;
    logic                           mag_vld_reg;
    logic                           m_valid_reg;
    logic [PEAK_BITS-1:0]           m_peak_reg;

    logic [CH_IW-1:0]               ch_idx;
    logic                           accept;
    logic                           ch_ignored;
    logic                           p_last;
    logic                           pipe_busy;
    logic                           out_load;
    coef_t                          coef_sel;
    logic signed [SAMPLE_BITS-1:0]  rd_val;
    logic signed [ACC_W-1:0]        prod_ext;
    logic signed [ACC_W-1:0]        acc_sum;
    logic [PEAK_BITS-1:0]           s_ext;
    logic [PEAK_BITS-1:0]           s_abs;
    logic [ACC_W-1:0]               fin_abs;
    logic [ACC_W:0]                 mag_sum;
    logic [PEAK_BITS-1:0]           mag_sat;
    logic [PEAK_BITS-1:0]           peak_cand;
    logic                           peak_upd;

    assign ch_idx     = ch_reg[CH_IW-1:0];
    assign s_ready    = (state_reg == ST_IDLE);
    assign accept     = s_valid && s_ready;
    assign ch_ignored = ({1'b0, s_channel} >= 5'(MAX_CHANNELS));
    assign p_last     = (mode_reg == MODE_2X) ? (p_reg == 2'd1) : (p_reg == 2'd3);
    assign pipe_busy  = s1_vld_reg || s2_vld_reg || fin_vld_reg || mag_vld_reg;
    assign out_load   = (state_reg == ST_OUT) && (!m_valid_reg || m_ready);
    assign coef_sel   = (mode_reg == MODE_2X) ? coef2_rom[{k_reg, p_reg[0]}]
                                              : coef4_rom[{k_reg, p_reg}];
    assign rd_val     = rd_ok_reg ? rd_data_reg : '0;
    assign prod_ext   = ACC_W'(prod_reg);
    assign acc_sum    = acc_reg + prod_ext;
    assign s_ext      = {sample_reg[SAMPLE_BITS-1], sample_reg};
    assign s_abs      = sample_reg[SAMPLE_BITS-1] ? (~s_ext + 1'b1) : s_ext;
    assign fin_abs    = fin_reg[ACC_W-1] ? (~fin_reg + 1'b1) : fin_reg;
    assign mag_sum    = {1'b0, fin_abs} + (ACC_W+1)'(1 << (COEF_FRAC - 1));
    assign mag_sat    = (mag_reg > MAG_W'(PEAK_MAX)) ? PEAK_MAX : mag_reg[PEAK_BITS-1:0];
    assign peak_cand  = (state_reg == ST_WRITE) ? s_abs : mag_sat;
    assign peak_upd   = ((state_reg == ST_WRITE) || mag_vld_reg) && (peak_cand > peak_reg);
    assign m_valid      = m_valid_reg;
    assign m_peak_level = m_peak_reg;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    if (s_operation == OP_CLEAR || ch_ignored) begin
                        state_next = ST_OUT;
                    end else begin
                        state_next = ST_WRITE;
                    end
                end
            end
            ST_WRITE: begin
                state_next = (mode_reg == MODE_1X) ? ST_OUT : ST_MAC;
            end
            ST_MAC: begin
                if (k_reg == SLOT_LAST && p_last) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (!pipe_busy) begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                if (out_load) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // history memory, one write and one read port
    always_ff @(posedge aclk) begin
        if (state_reg == ST_WRITE && mode_reg != MODE_1X) begin
            hist_mem[ch_idx][slot_reg] <= sample_reg;
        end
        rd_data_reg <= hist_mem[ch_idx][at_reg];
    end

    // MAC datapath, accepted item capture and output peak register
    always_ff @(posedge aclk) begin
        coef_reg <= coef_sel;
        if (s1_vld_reg) begin
            prod_reg <= rd_val * coef_reg;
        end
        if (state_reg == ST_WRITE) begin
            acc_reg <= '0;
        end else if (s2_vld_reg) begin
            if (s2_last_reg) begin
                fin_reg <= acc_sum;
                acc_reg <= '0;
            end else begin
                acc_reg <= acc_sum;
            end
        end
        if (fin_vld_reg) begin
            mag_reg <= mag_sum[ACC_W:COEF_FRAC];
        end
        if (accept) begin
            op_reg     <= s_operation;
            ch_reg     <= s_channel;
            sample_reg <= s_sample;
            last_reg   <= s_frame_last;
        end
        if (out_load) begin
            m_peak_reg <= peak_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            mode_reg    <= MODE_4X;
            slot_reg    <= '0;
            at_reg      <= '0;
            k_reg       <= '0;
            p_reg       <= '0;
            peak_reg    <= '0;
            hist_ok_reg <= '0;
            rd_ok_reg   <= 1'b0;
            s1_vld_reg  <= 1'b0;
            s1_last_reg <= 1'b0;
            s2_vld_reg  <= 1'b0;
            s2_last_reg <= 1'b0;
            fin_vld_reg <= 1'b0;
            mag_vld_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            rd_ok_reg   <= hist_ok_reg[ch_idx][at_reg];
            s1_vld_reg  <= (state_reg == ST_MAC);
            s1_last_reg <= (k_reg == SLOT_LAST);
            s2_vld_reg  <= s1_vld_reg;
            s2_last_reg <= s1_last_reg;
            fin_vld_reg <= s2_vld_reg && s2_last_reg;
            mag_vld_reg <= fin_vld_reg;

            if (peak_upd) begin
                peak_reg <= peak_cand;
            end

            if (cfg_wr_en) begin
                mode_reg    <= cfg_wr_data;
                slot_reg    <= '0;
                peak_reg    <= '0;
                hist_ok_reg <= '0;
            end

            case (state_reg)
                ST_IDLE: begin
                    if (accept && s_operation == OP_CLEAR) begin
                        slot_reg    <= '0;
                        peak_reg    <= '0;
                        hist_ok_reg <= '0;
                    end
                end
                ST_WRITE: begin
                    if (mode_reg != MODE_1X) begin
                        hist_ok_reg[ch_idx][slot_reg] <= 1'b1;
                    end
                    at_reg <= slot_reg;
                    k_reg  <= '0;
                    p_reg  <= '0;
                end
                ST_MAC: begin
                    if (k_reg == SLOT_LAST) begin
                        k_reg  <= '0;
                        at_reg <= slot_reg;
                        p_reg  <= p_reg + 2'd1;
                    end else begin
                        k_reg  <= k_reg + 1'b1;
                        at_reg <= (at_reg == '0) ? SLOT_LAST : at_reg - 1'b1;
                    end
                end
                ST_OUT: begin
                    if (out_load && op_reg == OP_SAMPLE && last_reg) begin
                        slot_reg <= (slot_reg == SLOT_LAST) ? '0 : slot_reg + 1'b1;
                    end
                end
                default: begin
                end
            endcase

            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    `TPOM_ASSERT_NXT(a_busy_after_accept, aclk, aresetn, accept, !s_ready)
    `TPOM_ASSERT_IMP(a_pipe_empty_idle, aclk, aresetn, state_reg == ST_IDLE, !pipe_busy)
    `TPOM_ASSERT_NXT(a_peak_monotonic, aclk, aresetn, !(accept && s_operation == OP_CLEAR) && !cfg_wr_en, peak_reg >= $past(peak_reg))
    `TPOM_ASSERT_IMP(a_mac_not_1x, aclk, aresetn, state_reg == ST_MAC, mode_reg != MODE_1X)

endmodule
`default_nettype wire
